// ===== hdl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// Request and status codes, controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int POS_W   = 5;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [KIND_W-1:0] REQ_INSERT   = 3'd1;
  localparam logic [KIND_W-1:0] REQ_REM_LAST = 3'd2;
  localparam logic [KIND_W-1:0] REQ_REM_AT   = 3'd3;
  localparam logic [KIND_W-1:0] REQ_COUNT    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PREP,
    S_MOVE,
    S_FINISH
  } ple_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;   // capture the request beat
    logic load;    // register the evaluation and shift setup
    logic prep;    // issue the first read of a shift
    logic move;    // write one shifted entry, read the next
    logic finish;  // commit and present the result
  } ple_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_shift;
    logic last_move;
  } ple_sts_t;

endpackage

`default_nettype wire

// ===== hdl/positional_list_engine_unit.sv =====
// Top level of the positional list engine: controller plus datapath.
// Depends on ple_pkg, ple_ctrl and ple_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Positional list engine
// Holds an ordered list of up to DEPTH signed 32-bit entries and serves one
// request at a time: append, insert at a 1-based position, remove last,
// remove at a 1-based position, or count query.
//
// Request channel: drive req_type, position and value and raise start; the
// beat is taken at the rising edge where start is high and busy is low.
// busy stays high until the request has been committed.
//
// Result channel: done pulses for exactly one cycle with entry_count (entries
// held after the request) and status (ok, full, empty, out of range). The
// receiver must take the beat in that cycle; there is no back-pressure.
//
// Sequencing: a request that moves no entries (append, remove last, count query,
// any failed request) goes from the checks straight to commit. Insert or remove
// at a position moves n entries, n up to DEPTH-1, one per cycle after a
// read-ahead step, then commits. A new request can be accepted in the done cycle.
// Reset (rst, synchronous) empties the list and clears done; entry storage
// itself is not cleared, since only written entries are ever moved.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [KIND_W-1:0]         req_type,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           done,
  output logic [COUNT_W-1:0]             entry_count,
  output logic [STAT_W-1:0]              status
);

  ple_cmd_t cmd;
  ple_sts_t sts;

  // Sequence the request: capture, check, shift, commit
  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the list, run the checks and move entries
  ple_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .position    (position),
    .value       (value),
    .sts         (sts),
    .entry_count (entry_count),
    .status      (status),
    .done        (done)
  );

endmodule

`default_nettype wire

// ===== hdl/ple_ctrl.sv =====
// Controller state machine of the positional list engine.
// Depends on ple_pkg; drives commands to ple_datapath.
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ple_sts_t sts,
  output ple_cmd_t      cmd,
  output logic          busy
);

  ple_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.load   = 1'b1;
        state_next = sts.need_shift ? S_PREP : S_FINISH;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (sts.last_move) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ple_datapath.sv =====
// Datapath of the positional list engine: request registers, checks,
// entry memory with one write and one registered read port, shift counters.
// Depends on ple_pkg; commanded by ple_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ple_datapath
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ple_cmd_t                  cmd,
  input  wire logic [KIND_W-1:0]         req_type,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic signed [VALUE_W-1:0] value,
  output ple_sts_t                       sts,
  output logic [COUNT_W-1:0]             entry_count,
  output logic [STAT_W-1:0]              status,
  output logic                           done
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          pos;
  logic signed [VALUE_W-1:0] val;
  logic [CW-1:0]             count;
  logic [STAT_W-1:0]         st;
  logic                      is_ins;
  logic                      is_rem;
  logic [CW-1:0]             ep;
  logic [AW-1:0]             k;
  logic [CW-1:0]             rem;
  logic signed [VALUE_W-1:0] rd_data;

  logic [XW-1:0]     cx, px, e_ep, e_n;
  logic [STAT_W-1:0] e_st;
  logic              e_ins, e_rem, full, empty;
  logic [AW-1:0]     e_k, k_next, rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic signed [VALUE_W-1:0] wr_data;
  logic [CW-1:0]     count_next;
  logic [XW-1:0]     count_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind <= req_type;
      pos  <= position;
      val  <= value;
    end
  end

  // Request checks: full and empty come before the position check
  always_comb begin
    cx    = XW'(count);
    px    = XW'(pos);
    full  = (cx == XW'(DEPTH));
    empty = (cx == '0);
    e_st  = STAT_OK;
    e_ins = 1'b0;
    e_rem = 1'b0;
    e_ep  = '0;
    e_n   = '0;
    unique case (kind)
      REQ_APPEND: begin
        if (full) begin
          e_st = STAT_FULL;
        end else begin
          e_ins = 1'b1;
          e_ep  = cx + XW'(1);
        end
      end
      REQ_INSERT: begin
        if (full) begin
          e_st = STAT_FULL;
        end else if (px == '0 || px > cx + XW'(1)) begin
          e_st = STAT_RANGE;
        end else begin
          e_ins = 1'b1;
          e_ep  = px;
          e_n   = cx + XW'(1) - px;
        end
      end
      REQ_REM_LAST: begin
        if (empty) begin
          e_st = STAT_EMPTY;
        end else begin
          e_rem = 1'b1;
          e_ep  = cx;
        end
      end
      REQ_REM_AT: begin
        if (empty) begin
          e_st = STAT_EMPTY;
        end else if (px == '0 || px > cx) begin
          e_st = STAT_RANGE;
        end else begin
          e_rem = 1'b1;
          e_ep  = px;
          e_n   = cx - px;
        end
      end
      default: begin
        e_st = STAT_OK;
      end
    endcase
    // Insert shifts from the tail down, remove from the gap up
    e_k = e_ins ? AW'(count) : AW'(e_ep - XW'(1));
  end

  assign sts.need_shift = (e_n != '0);
  assign sts.last_move  = (rem == CW'(1));

  assign k_next  = is_ins ? (k - AW'(1)) : (k + AW'(1));
  assign rd_addr = cmd.prep ? (is_ins ? (k - AW'(1)) : (k + AW'(1)))
                            : (is_ins ? (k - AW'(2)) : (k + AW'(2)));
  assign rd_en   = cmd.prep | (cmd.move & ~sts.last_move);

  assign wr_en   = cmd.move | (cmd.finish & (st == STAT_OK) & is_ins);
  assign wr_addr = cmd.move ? k : AW'(ep - CW'(1));
  assign wr_data = cmd.move ? rd_data : val;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st     <= e_st;
      is_ins <= e_ins;
      is_rem <= e_rem;
      ep     <= CW'(e_ep);
      rem    <= CW'(e_n);
      k      <= e_k;
    end else if (cmd.move) begin
      rem <= rem - CW'(1);
      k   <= k_next;
    end
  end

  always_comb begin
    count_next = count;
    if (st == STAT_OK) begin
      if (is_ins) begin
        count_next = count + CW'(1);
      end else if (is_rem) begin
        count_next = count - CW'(1);
      end
    end
  end

  assign count_ext = XW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.finish) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entry_count <= count_ext[COUNT_W-1:0];
      status      <= st;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ple_checker.sv =====
// Port-level assertions for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

module ple_checker
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire logic [COUNT_W-1:0] entry_count,
  input wire logic [STAT_W-1:0]  status
);

  // A result beat lasts one cycle and is never back to back
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted beat makes the block busy and gives no result right away
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not hold busy");

  // A full list reports its depth
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (entry_count == COUNT_W'(DEPTH)))
    else $error("full status with wrong entry count");

  // An empty list reports zero entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero entry count");

endmodule

bind positional_list_engine_unit ple_checker #(
  .DEPTH (DEPTH)
) u_ple_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .entry_count (entry_count),
  .status      (status)
);

`default_nettype wire

// ===== dv/positional_list_engine_unit_test.sv =====
// Self-checking testbench for positional_list_engine_unit: predicts the entry count and
// status of every request beat and checks each done beat against that prediction.
// Depends on ple_pkg and the positional_list_engine_unit RTL.
`timescale 1ns / 1ps

module positional_list_engine_unit_test
  import ple_pkg::*;
;

  localparam int LIST_DEPTH  = 16;
  localparam int ITEM_TARGET = 450;
  // Tail of the run where the sender never pauses
  localparam int STEADY_TAIL = 60;
  // Settle time after the final drain, longer than the slowest request
  localparam int SETTLE_CYCLES = 30;

  // Request codes the block treats like a count query
  localparam logic [KIND_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef enum int {
    MODE_GROW,
    MODE_SHRINK,
    MODE_CHURN
  } load_mode_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status;
  } list_reply_t;

  // Shadow list plus the queue of replies still owed by the block.
  class list_scoreboard_t;
    logic signed [VALUE_W-1:0] shadow [LIST_DEPTH];
    int          held;
    int          peak;
    list_reply_t owed [$];
    int          mismatches;
    int          replies;
    int          status_seen [4];

    function new();
      held = 0;
      peak = 0;
      mismatches = 0;
      replies = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void fail_note(string text);
      mismatches++;
      if (mismatches <= 10) $display("%s", text);
    endfunction

    // Insert at a 1-based slot; slot held+1 appends.
    function logic [STAT_W-1:0] place_entry(int slot, logic signed [VALUE_W-1:0] val);
      int i;
      if (held >= LIST_DEPTH) return STAT_FULL;
      if (slot < 1 || slot > held + 1) return STAT_RANGE;
      for (i = held; i >= slot; i--) shadow[i] = shadow[i-1];
      shadow[slot-1] = val;
      held++;
      return STAT_OK;
    endfunction

    // Remove at a 1-based slot and close the gap.
    function logic [STAT_W-1:0] drop_entry(int slot);
      int i;
      if (held == 0) return STAT_EMPTY;
      if (slot < 1 || slot > held) return STAT_RANGE;
      for (i = slot - 1; i + 1 < held; i++) shadow[i] = shadow[i+1];
      held--;
      return STAT_OK;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic signed [VALUE_W-1:0] val);
      list_reply_t want;
      case (kind)
        REQ_APPEND:   want.status = place_entry(held + 1, val);
        REQ_INSERT:   want.status = place_entry(int'(pos), val);
        REQ_REM_LAST: want.status = drop_entry(held);
        REQ_REM_AT:   want.status = drop_entry(int'(pos));
        default:      want.status = STAT_OK;
      endcase
      want.count = held[COUNT_W-1:0];
      if (held > peak) peak = held;
      owed.push_back(want);
    endfunction

    function void check_result(logic [COUNT_W-1:0] count, logic [STAT_W-1:0] status);
      list_reply_t want;
      replies++;
      if (status !== 2'bxx) status_seen[status]++;
      if (owed.size() == 0) begin
        fail_note($sformatf("%0t: done beat with nothing owed (count %0d, status %0d)",
                            $time, count, status));
        return;
      end
      want = owed.pop_front();
      if (count !== want.count)
        fail_note($sformatf("%0t: entry_count expected %0d, got %0d",
                            $time, want.count, count));
      if (status !== want.status)
        fail_note($sformatf("%0t: status expected %0d, got %0d",
                            $time, want.status, status));
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [KIND_W-1:0]         req_type = REQ_COUNT;
  logic [POS_W-1:0]          position = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      busy;
  logic                      done;
  logic [COUNT_W-1:0]        entry_count;
  logic [STAT_W-1:0]         status;

  list_scoreboard_t sb;
  int               sent = 0;

  positional_list_engine_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .position   (position),
    .value      (value),
    .done       (done),
    .entry_count(entry_count),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Watch both channels at every edge. Check the result first, then note
  // the new request, so a done beat that lands on an accept edge pops the
  // older expectation before the new one is queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(entry_count, status);
      if (start && !busy) sb.note_request(req_type, position, value);
    end
  end

  // Present one request beat and hold it until the block takes it. Returns
  // on the accept edge with start still high.
  task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic signed [VALUE_W-1:0] val);
    start    <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // Drop start for a burst of idle cycles.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every owed result has come back.
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Build one random request. Most beats are well formed for the current
  // list length so the list really fills and empties; the rest is noise
  // with any code and any position.
  task automatic send_random(input load_mode_t mode);
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    int                        fill;
    int                        roll;
    fill = sb.held;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       val = VALUE_MIN;
      1:       val = VALUE_MAX;
      default: val = $urandom;
    endcase
    pos = POS_W'($urandom_range(0, 31));
    if (roll < 12) begin
      kind = KIND_W'($urandom_range(0, 7));
    end else begin
      case (mode)
        MODE_GROW:   kind = (roll % 2) ? REQ_APPEND : REQ_INSERT;
        MODE_SHRINK: kind = (roll % 2) ? REQ_REM_LAST : REQ_REM_AT;
        default:     kind = KIND_W'($urandom_range(REQ_APPEND, REQ_COUNT));
      endcase
      if (kind == REQ_INSERT) pos = POS_W'($urandom_range(1, fill + 1));
      else if (kind == REQ_REM_AT) pos = POS_W'($urandom_range(1, (fill > 0) ? fill : 1));
    end
    send_beat(kind, pos, val);
  endtask

  initial begin
    load_mode_t mode;
    int         block_len;
    int         k;
    int         code;
    bit         gaps_on;
    bit         drained;

    sb = new();
    drained = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list checks, position edges, head/tail inserts,
    // removal down to empty, and the spare request codes.
    send_beat(REQ_COUNT, 5'd0, '0);
    send_beat(REQ_REM_LAST, 5'd0, '0);       // empty beats position check
    send_beat(REQ_REM_AT, 5'd1, '0);
    send_beat(REQ_REM_AT, 5'd0, '0);
    send_beat(REQ_INSERT, 5'd0, VALUE_MAX);  // position zero is never valid
    send_beat(REQ_INSERT, 5'd2, VALUE_MAX);  // past count+1 on an empty list
    send_beat(REQ_APPEND, 5'd0, VALUE_MAX);
    hold_off($urandom_range(1, 13));
    send_beat(REQ_INSERT, 5'd1, VALUE_MIN);  // new head
    send_beat(REQ_INSERT, 5'd3, -32'sd1);    // count+1 acts as append
    send_beat(REQ_INSERT, 5'd31, '0);
    send_beat(REQ_REM_AT, 5'd0, '0);
    send_beat(REQ_REM_AT, 5'd4, '0);         // one past the tail
    hold_off($urandom_range(1, 13));
    send_beat(REQ_REM_AT, 5'd2, '0);
    send_beat(REQ_REM_AT, 5'd2, '0);         // tail by position
    send_beat(REQ_REM_LAST, 5'd0, '0);       // single entry, list goes empty
    send_beat(REQ_COUNT, 5'd31, '1);
    for (code = REQ_SPARE_LO; code <= REQ_SPARE_HI; code++)
      send_beat(code[KIND_W-1:0], 5'd16, '1);

    // Random: blocks with a fill bias. Open with a growth block so the
    // full-list cases show up early.
    mode = MODE_GROW;
    while (sent < ITEM_TARGET) begin
      block_len = $urandom_range(8, 30);
      gaps_on = ($urandom_range(0, 2) != 0);
      for (k = 0; k < block_len && sent < ITEM_TARGET; k++) begin
        send_random(mode);
        if (!drained && sent >= ITEM_TARGET / 2) begin
          drain_replies();
          drained = 1'b1;
        end else if (gaps_on && sent < ITEM_TARGET - STEADY_TAIL &&
                     $urandom_range(0, 2) == 0) begin
          hold_off($urandom_range(1, 13));
        end
      end
      mode = load_mode_t'($urandom_range(0, 2));
    end

    // Wind down: let every owed result arrive, then watch for strays.
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.fail_note($sformatf("%0d expected results never came", sb.owed.size()));

    $display("Summary: %0d requests sent, %0d results seen, list peaked at %0d entries",
             sent, sb.replies, sb.peak);
    $display("Summary: status ok/full/empty/range = %0d/%0d/%0d/%0d, mismatches %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL],
             sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_RANGE], sb.mismatches);
    if (sb.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
